// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 stream decoder
// Word structs for both channels, the group result struct and the
// character classification function.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Character class codes: 0..63 are alphabet values
  localparam logic [6:0] PadCode = 7'd64;
  localparam logic [6:0] NoCode  = 7'd65;

  // Group accumulator geometry
  localparam int unsigned AccWidth = 24;
  localparam int unsigned CntWidth = 2;

  // Input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       stream_end;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
  } out_word_t;

  // Bytes released by one input word: the first count bytes of bytes,
  // most significant first
  typedef struct packed {
    logic [AccWidth-1:0] bytes;
    logic [CntWidth-1:0] count;
  } grp_res_t;

  // Map a character code to its six-bit value, PadCode or NoCode
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [6:0] v;
    v = NoCode;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == 8'h3D) begin
      v = PadCode;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming base64 decoder, one character a word
//
//   channel | direction | word type   | handshake
//   in      | input     | in_word_t   | in_valid_i / in_ready_o
//   out     | output    | out_word_t  | out_valid_o / out_ready_i
//
// One input word is taken per cycle; it is decoded the cycle after it lands in
// the input register and its bytes leave the serializer one per cycle while
// accepted. A word that releases bytes waits in the input register until the
// serializer is empty or hands out its final byte in that cycle; other words
// pass at once. Reset clears the group state, input register and serializer.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64d_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64d_pkg::out_word_t out_data_o
);

  logic               in_vld_q, in_vld_d;
  b64d_pkg::in_word_t in_q;
  b64d_pkg::grp_res_t res;
  logic               can_load, take, load;

  // Consume the held word when its bytes fit
  assign take       = in_vld_q && ((res.count == '0) || can_load);
  assign load       = take && (res.count != '0);
  assign in_ready_o = !in_vld_q || take;

  // Input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  b64d_group u_group (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (in_q),
    .take_i (take),
    .res_o  (res)
  );

  b64d_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_i      (load),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/b64d_group.sv =====
// ----------------------------------------------------------------------------
// b64d_group: group position and byte accumulator
// Classifies one character, works out which bytes it releases and
// updates the group state when the word is consumed.
// ----------------------------------------------------------------------------
module b64d_group (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::in_word_t  word_i,
  input  logic                take_i,
  output b64d_pkg::grp_res_t  res_o
);

  logic [1:0]                         pos_q, pos_d;
  logic [b64d_pkg::AccWidth-1:0]      acc_q, acc_d;
  logic [6:0]                         val;
  logic                               is_pad, is_val, restart;
  logic [b64d_pkg::AccWidth-1:0]      acc_upd;
  logic [1:0]                         pos_after;

  // Classify and merge the new value into the accumulator
  always_comb begin
    val     = b64d_pkg::char_value(word_i.in_char);
    is_pad  = (val == b64d_pkg::PadCode);
    is_val  = (val < b64d_pkg::PadCode);
    acc_upd = acc_q;
    if (is_val) begin
      case (pos_q)
        2'd0:    acc_upd = acc_q | {val[5:0], 18'b0};
        2'd1:    acc_upd = acc_q | {6'b0, val[5:0], 12'b0};
        2'd2:    acc_upd = acc_q | {12'b0, val[5:0], 6'b0};
        default: acc_upd = acc_q | {18'b0, val[5:0]};
      endcase
    end
    pos_after = is_val ? pos_q + 2'd1 : pos_q;
  end

  // Byte count released by this word
  always_comb begin
    res_o.bytes = acc_upd;
    res_o.count = 2'd0;
    restart     = 1'b0;
    if (is_pad) begin
      restart = 1'b1;
      case (pos_q)
        2'd1, 2'd2: res_o.count = 2'd1;
        2'd3:       res_o.count = 2'd2;
        default:    res_o.count = 2'd0;
      endcase
    end else if (is_val && pos_q == 2'd3) begin
      restart     = 1'b1;
      res_o.count = 2'd3;
    end else if (word_i.stream_end) begin
      restart = 1'b1;
      if (pos_after != 2'd0) begin
        res_o.count = 2'd3;
      end
    end
  end

  // Next group state
  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (take_i) begin
      if (restart) begin
        pos_d = 2'd0;
        acc_d = '0;
      end else begin
        pos_d = pos_after;
        acc_d = acc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ===== rtl/core/b64d_out.sv =====
// ----------------------------------------------------------------------------
// b64d_out: output byte serializer
// Holds up to three released bytes and hands them out one word per cycle
// while out_ready_i is high, flagging the last byte of each group.
// ----------------------------------------------------------------------------
module b64d_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::grp_res_t  res_i,
  input  logic                load_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64d_pkg::out_word_t out_data_o
);

  logic [b64d_pkg::AccWidth-1:0] buf_q, buf_d;
  logic [b64d_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                          pop;

  assign out_valid_o          = (cnt_q != '0);
  assign out_data_o.data_byte = buf_q[b64d_pkg::AccWidth-1 -: 8];
  assign out_data_o.run_last  = (cnt_q == 2'd1);
  assign pop                  = out_valid_o && out_ready_i;

  // Free now, or freed by the final pop in this cycle
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  // Shift out one byte per accepted word, reload on a new group
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (pop) begin
      buf_d = {buf_q[b64d_pkg::AccWidth-9:0], 8'b0};
      cnt_d = cnt_q - 2'd1;
    end
    if (load_i) begin
      buf_d = res_i.bytes;
      cnt_d = res_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule
